// ===== rtl/arc_vertex_generator_macros.svh =====
// assertion macros shared by the arc vertex generator rtl
`ifndef ARC_VERTEX_GENERATOR_MACROS_SVH
`define ARC_VERTEX_GENERATOR_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define AVG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define AVG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/avg_pkg.sv =====
// types, constants and tables shared by the arc vertex generator
`timescale 1ns / 1ps
`default_nettype none

package avg_pkg;

  // item field widths
  localparam int ANGLE_W  = 16;
  localparam int RADIUS_W = 16;
  localparam int SEG_W    = 6;
  localparam int COORD_W  = 16;

  // defaults for the top level parameters
  localparam int MAX_SEGMENTS_DEF = 62;
  localparam int CORDIC_STEPS_DEF = 16;

  // internal widths
  localparam int SPAN_W     = 15;                // a full turn in q3.12 fits
  localparam int ACC_W      = 18;                // start plus i*step
  localparam int Z_W        = 34;                // residual angle, q.28
  localparam int XY_W       = 32;                // rotator vector, q.30
  localparam int ATAN_IDX_W = 5;
  localparam int PROD_W     = RADIUS_W + XY_W;
  localparam int OUT_SHIFT  = 30;
  localparam int SCALED_W   = PROD_W - OUT_SHIFT;

  // angle limits in q3.12
  localparam logic signed [ANGLE_W-1:0] TWO_PI_Q12     = 16'sd25736;
  localparam logic signed [ANGLE_W-1:0] NEG_TWO_PI_Q12 = -16'sd25736;
  localparam logic [SPAN_W-1:0]         FULL_SPAN      = 15'd25736;

  // rotator constants in q.28 and q.30
  localparam logic signed [Z_W-1:0]  PI_W          = 34'sd843314857;
  localparam logic signed [Z_W-1:0]  NEG_PI_W      = -34'sd843314857;
  localparam logic signed [Z_W-1:0]  TWO_PI_W      = 34'sd1686629713;
  localparam logic signed [Z_W-1:0]  HALF_PI_W     = 34'sd421657428;
  localparam logic signed [Z_W-1:0]  NEG_HALF_PI_W = -34'sd421657428;
  localparam logic signed [XY_W-1:0] GAIN_Q30      = 32'sd652032874;

  // result status codes
  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_BAD_START  = 3'd1,
    STATUS_BAD_END    = 3'd2,
    STATUS_BAD_RADIUS = 3'd3,
    STATUS_ZERO_SEG   = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0]  start_angle;
    logic signed [ANGLE_W-1:0]  end_angle;
    logic signed [RADIUS_W-1:0] arc_radius;
    logic [SEG_W-1:0]           segments;
  } request_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    status_t                   status;
    logic                      last;
  } vertex_t;

  // rotator handshake back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } cordic_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ERROR,
    S_DIVIDE,
    S_POINT,
    S_WAIT,
    S_EMIT,
    S_REPEAT
  } seq_state_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_REDUCE,
    C_FOLD,
    C_ROTATE,
    C_SCALE_X,
    C_SCALE_Y,
    C_FINISH
  } cordic_state_t;

  // arctangent of 2^-i in q.28
  function automatic logic signed [Z_W-1:0] atan_q28(input logic [ATAN_IDX_W-1:0] idx);
    case (idx)
      5'd0:    atan_q28 = 34'sd210828714;
      5'd1:    atan_q28 = 34'sd124459457;
      5'd2:    atan_q28 = 34'sd65760959;
      5'd3:    atan_q28 = 34'sd33381290;
      5'd4:    atan_q28 = 34'sd16755422;
      5'd5:    atan_q28 = 34'sd8385879;
      5'd6:    atan_q28 = 34'sd4193963;
      5'd7:    atan_q28 = 34'sd2097109;
      5'd8:    atan_q28 = 34'sd1048571;
      5'd9:    atan_q28 = 34'sd524287;
      5'd10:   atan_q28 = 34'sd262144;
      5'd11:   atan_q28 = 34'sd131072;
      5'd12:   atan_q28 = 34'sd65536;
      5'd13:   atan_q28 = 34'sd32768;
      5'd14:   atan_q28 = 34'sd16384;
      5'd15:   atan_q28 = 34'sd8192;
      5'd16:   atan_q28 = 34'sd4096;
      5'd17:   atan_q28 = 34'sd2048;
      5'd18:   atan_q28 = 34'sd1024;
      5'd19:   atan_q28 = 34'sd512;
      5'd20:   atan_q28 = 34'sd256;
      5'd21:   atan_q28 = 34'sd128;
      5'd22:   atan_q28 = 34'sd64;
      5'd23:   atan_q28 = 34'sd32;
      default: atan_q28 = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/avg_div.sv =====
// bit-serial restoring divider for the angle step
`timescale 1ns / 1ps
`default_nettype none

module avg_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [avg_pkg::SPAN_W-1:0] dividend,
  input  logic [avg_pkg::SEG_W-1:0]  divisor,
  output logic                       done,
  output logic [avg_pkg::SPAN_W-1:0] quotient
);

  localparam int SPAN_W = avg_pkg::SPAN_W;
  localparam int SEG_W  = avg_pkg::SEG_W;
  localparam int CNT_W  = $clog2(SPAN_W);

  logic              busy;
  logic [CNT_W-1:0]  count;
  logic [SPAN_W-1:0] quo;
  logic [SEG_W-1:0]  rem;
  logic [SEG_W-1:0]  dsr;
  logic [SEG_W:0]    trial;
  logic              fits;
  logic [SEG_W:0]    rem_next;

  // one quotient bit per cycle, dividend shifts out of the quotient register
  always_comb begin
    trial    = {rem, quo[SPAN_W-1]};
    fits     = trial >= {1'b0, dsr};
    rem_next = fits ? trial - {1'b0, dsr} : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      dsr   <= divisor;
      rem   <= '0;
      count <= CNT_W'(SPAN_W - 1);
    end else if (busy) begin
      quo   <= {quo[SPAN_W-2:0], fits};
      rem   <= rem_next[SEG_W-1:0];
      count <= count - 1'b1;
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ===== rtl/avg_cordic.sv =====
// shared rotation cordic with angle reduction and radius scaling
`timescale 1ns / 1ps
`default_nettype none

module avg_cordic #(
  parameter int CORDIC_STEPS = avg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [avg_pkg::ACC_W-1:0]    angle,
  input  logic signed [avg_pkg::RADIUS_W-1:0] radius,
  output avg_pkg::cordic_status_t             stat,
  output logic signed [avg_pkg::COORD_W-1:0]  point_x,
  output logic signed [avg_pkg::COORD_W-1:0]  point_y
);

  localparam int Z_W        = avg_pkg::Z_W;
  localparam int XY_W       = avg_pkg::XY_W;
  localparam int ACC_W      = avg_pkg::ACC_W;
  localparam int RADIUS_W   = avg_pkg::RADIUS_W;
  localparam int COORD_W    = avg_pkg::COORD_W;
  localparam int PROD_W     = avg_pkg::PROD_W;
  localparam int OUT_SHIFT  = avg_pkg::OUT_SHIFT;
  localparam int SCALED_W   = avg_pkg::SCALED_W;
  localparam int ATAN_IDX_W = avg_pkg::ATAN_IDX_W;
  localparam int IW         = $clog2(CORDIC_STEPS);
  localparam int Z_SHIFT    = Z_W - ACC_W;

  localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);
  localparam logic signed [PROD_W-1:0] ROUND_BIAS =
    {{(PROD_W - OUT_SHIFT){1'b0}}, 1'b1, {(OUT_SHIFT - 1){1'b0}}};
  localparam logic signed [SCALED_W-1:0] SAT_HI =
    {{(SCALED_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
  localparam logic signed [SCALED_W-1:0] SAT_LO =
    {{(SCALED_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};

  avg_pkg::cordic_state_t state, state_next;

  logic signed [Z_W-1:0]      z;
  logic signed [XY_W-1:0]     x;
  logic signed [XY_W-1:0]     y;
  logic                       neg;
  logic [IW-1:0]              step_idx;
  logic signed [RADIUS_W-1:0] radius_r;
  logic signed [PROD_W-1:0]   prod;
  logic signed [COORD_W-1:0]  px;
  logic signed [COORD_W-1:0]  py;

  logic                       z_hi;
  logic                       z_lo;
  logic signed [XY_W-1:0]     dx;
  logic signed [XY_W-1:0]     dy;
  logic signed [Z_W-1:0]      at;
  logic signed [XY_W-1:0]     c_base;
  logic signed [XY_W-1:0]     c_sel;

  // round half up, drop the q.30 fraction and clamp to q8.8
  function automatic logic signed [COORD_W-1:0] saturate(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0]   r;
    logic signed [SCALED_W-1:0] s;
    r = p + ROUND_BIAS;
    s = r[PROD_W-1:OUT_SHIFT];
    if (s > SAT_HI) begin
      saturate = SAT_HI[COORD_W-1:0];
    end else if (s < SAT_LO) begin
      saturate = SAT_LO[COORD_W-1:0];
    end else begin
      saturate = s[COORD_W-1:0];
    end
  endfunction

  // shared shift, add and compare terms
  always_comb begin
    z_hi   = z > avg_pkg::PI_W;
    z_lo   = z < avg_pkg::NEG_PI_W;
    dx     = y >>> step_idx;
    dy     = x >>> step_idx;
    at     = avg_pkg::atan_q28(ATAN_IDX_W'(step_idx));
    c_base = (state == avg_pkg::C_SCALE_X) ? x : y;
    c_sel  = neg ? -c_base : c_base;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      avg_pkg::C_IDLE:    if (start) state_next = avg_pkg::C_REDUCE;
      avg_pkg::C_REDUCE:  if (!z_hi && !z_lo) state_next = avg_pkg::C_FOLD;
      avg_pkg::C_FOLD:    state_next = avg_pkg::C_ROTATE;
      avg_pkg::C_ROTATE:  if (step_idx == LAST_STEP) state_next = avg_pkg::C_SCALE_X;
      avg_pkg::C_SCALE_X: state_next = avg_pkg::C_SCALE_Y;
      avg_pkg::C_SCALE_Y: state_next = avg_pkg::C_FINISH;
      avg_pkg::C_FINISH:  state_next = avg_pkg::C_IDLE;
      default:            state_next = avg_pkg::C_IDLE;
    endcase
  end

  // status outputs
  always_comb begin
    stat.busy = state != avg_pkg::C_IDLE;
    stat.done = state == avg_pkg::C_FINISH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= avg_pkg::C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      avg_pkg::C_IDLE: begin
        if (start) begin
          z        <= {angle, {Z_SHIFT{1'b0}}};
          x        <= avg_pkg::GAIN_Q30;
          y        <= '0;
          neg      <= 1'b0;
          step_idx <= '0;
          radius_r <= radius;
        end
      end
      avg_pkg::C_REDUCE: begin
        // bring the angle into plus or minus pi
        if (z_hi) begin
          z <= z - avg_pkg::TWO_PI_W;
        end else if (z_lo) begin
          z <= z + avg_pkg::TWO_PI_W;
        end
      end
      avg_pkg::C_FOLD: begin
        // fold into the right half plane, negating the result
        if (z > avg_pkg::HALF_PI_W) begin
          z   <= z - avg_pkg::PI_W;
          neg <= 1'b1;
        end else if (z < avg_pkg::NEG_HALF_PI_W) begin
          z   <= z + avg_pkg::PI_W;
          neg <= 1'b1;
        end
      end
      avg_pkg::C_ROTATE: begin
        if (!z[Z_W-1]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        step_idx <= step_idx + 1'b1;
      end
      avg_pkg::C_SCALE_X: begin
        prod <= PROD_W'(radius_r) * PROD_W'(c_sel);
      end
      avg_pkg::C_SCALE_Y: begin
        prod <= PROD_W'(radius_r) * PROD_W'(c_sel);
        px   <= saturate(prod);
      end
      avg_pkg::C_FINISH: begin
        py <= saturate(prod);
      end
      default: begin
        neg <= 1'b0;
      end
    endcase
  end

  assign point_x = px;
  assign point_y = py;

endmodule

`default_nettype wire

// ===== rtl/arc_vertex_generator.sv =====
// top level of the arc vertex generator: request checks, sequencer and output register
//
// channel   dir   handshake                        payload
// request   in    request_valid / request_stall    avg_pkg::request_t
// vertex    out   vertex_valid / vertex_stall      avg_pkg::vertex_t
//
// a good request with n segments yields n + 1 points, one more for a full circle;
// per point the shared cordic reduces the angle into plus or minus pi, folds it, runs
// the rotations and two multiplies, and the step divider runs once before the first point
// rst is synchronous and clears the sequencer, rotator and divider control and vertex_valid
// a stalled vertex holds in the output register while the sequencer waits to load the next
// request_stall is low only while the sequencer is idle
`timescale 1ns / 1ps
`default_nettype none

`include "arc_vertex_generator_macros.svh"

module arc_vertex_generator #(
  parameter int MAX_SEGMENTS = avg_pkg::MAX_SEGMENTS_DEF,
  parameter int CORDIC_STEPS = avg_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  input  avg_pkg::request_t request,
  output logic              vertex_valid,
  input  logic              vertex_stall,
  output avg_pkg::vertex_t  vertex
);

  localparam int ANGLE_W    = avg_pkg::ANGLE_W;
  localparam int SEG_W      = avg_pkg::SEG_W;
  localparam int SPAN_W     = avg_pkg::SPAN_W;
  localparam int ACC_W      = avg_pkg::ACC_W;
  localparam int COORD_W    = avg_pkg::COORD_W;
  localparam int SPAN_CMP_W = ANGLE_W + 1;

  localparam logic [SEG_W-1:0]      SEG_CAP   = SEG_W'(MAX_SEGMENTS);
  localparam logic [SPAN_CMP_W-1:0] FULL_WIDE = SPAN_CMP_W'(avg_pkg::FULL_SPAN);

  avg_pkg::seq_state_t     state, state_next;
  avg_pkg::request_t       req_r;
  avg_pkg::status_t        chk_status;
  avg_pkg::vertex_t        out_item;
  avg_pkg::cordic_status_t cordic_stat;

  logic [SEG_W-1:0]            seg_r;
  logic                        full_r;
  logic [SPAN_W-1:0]           step_r;
  logic signed [ACC_W-1:0]     angle_r;
  logic [SEG_W-1:0]            idx;
  logic signed [COORD_W-1:0]   first_x;
  logic signed [COORD_W-1:0]   first_y;

  logic                        accept;
  logic                        out_free;
  logic                        out_load;
  logic                        div_start;
  logic                        div_done;
  logic [SPAN_W-1:0]           div_quotient;
  logic                        cordic_start;
  logic signed [COORD_W-1:0]   cordic_x;
  logic signed [COORD_W-1:0]   cordic_y;

  logic signed [SPAN_CMP_W-1:0] diff;
  logic [SPAN_CMP_W-1:0]        span_abs;
  logic                         full_chk;
  logic [SPAN_W-1:0]            span_eff;
  logic [SEG_W-1:0]             seg_eff;
  logic                         last_point;

  // request checks in priority order, span and clamped segment count
  always_comb begin
    if (req_r.start_angle >= avg_pkg::TWO_PI_Q12 ||
        req_r.start_angle <= avg_pkg::NEG_TWO_PI_Q12) begin
      chk_status = avg_pkg::STATUS_BAD_START;
    end else if (req_r.end_angle >= avg_pkg::TWO_PI_Q12 ||
                 req_r.end_angle <= avg_pkg::NEG_TWO_PI_Q12) begin
      chk_status = avg_pkg::STATUS_BAD_END;
    end else if (req_r.arc_radius[ANGLE_W-1] || req_r.arc_radius == '0) begin
      chk_status = avg_pkg::STATUS_BAD_RADIUS;
    end else if (req_r.segments == '0) begin
      chk_status = avg_pkg::STATUS_ZERO_SEG;
    end else begin
      chk_status = avg_pkg::STATUS_OK;
    end
    diff     = SPAN_CMP_W'(req_r.end_angle) - SPAN_CMP_W'(req_r.start_angle);
    span_abs = diff[SPAN_CMP_W-1] ? -diff : diff;
    full_chk = span_abs >= FULL_WIDE || span_abs == '0;
    span_eff = full_chk ? avg_pkg::FULL_SPAN : span_abs[SPAN_W-1:0];
    seg_eff  = (req_r.segments > SEG_CAP) ? SEG_CAP : req_r.segments;
  end

  assign out_free   = !vertex_valid || !vertex_stall;
  assign accept     = request_valid && !request_stall;
  assign last_point = idx == seg_r;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      avg_pkg::S_IDLE:   if (request_valid) state_next = avg_pkg::S_CHECK;
      avg_pkg::S_CHECK: begin
        if (chk_status != avg_pkg::STATUS_OK) begin
          state_next = avg_pkg::S_ERROR;
        end else begin
          state_next = avg_pkg::S_DIVIDE;
        end
      end
      avg_pkg::S_ERROR:  if (out_free) state_next = avg_pkg::S_IDLE;
      avg_pkg::S_DIVIDE: if (div_done) state_next = avg_pkg::S_POINT;
      avg_pkg::S_POINT:  state_next = avg_pkg::S_WAIT;
      avg_pkg::S_WAIT:   if (cordic_stat.done) state_next = avg_pkg::S_EMIT;
      avg_pkg::S_EMIT: begin
        if (out_free) begin
          if (!last_point) begin
            state_next = avg_pkg::S_POINT;
          end else if (full_r) begin
            state_next = avg_pkg::S_REPEAT;
          end else begin
            state_next = avg_pkg::S_IDLE;
          end
        end
      end
      avg_pkg::S_REPEAT: if (out_free) state_next = avg_pkg::S_IDLE;
      default:           state_next = avg_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    request_stall    = state != avg_pkg::S_IDLE;
    div_start        = state == avg_pkg::S_CHECK && chk_status == avg_pkg::STATUS_OK;
    cordic_start     = state == avg_pkg::S_POINT;
    out_load         = 1'b0;
    out_item.point_x = '0;
    out_item.point_y = '0;
    out_item.status  = avg_pkg::STATUS_OK;
    out_item.last    = 1'b1;
    case (state)
      avg_pkg::S_ERROR: begin
        out_load        = out_free;
        out_item.status = chk_status;
      end
      avg_pkg::S_EMIT: begin
        out_load         = out_free;
        out_item.point_x = cordic_x;
        out_item.point_y = cordic_y;
        out_item.last    = last_point && !full_r;
      end
      avg_pkg::S_REPEAT: begin
        out_load         = out_free;
        out_item.point_x = first_x;
        out_item.point_y = first_y;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= avg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture and per-arc bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= request;
    end
    if (div_start) begin
      seg_r   <= seg_eff;
      full_r  <= full_chk;
      angle_r <= ACC_W'(req_r.start_angle);
      idx     <= '0;
    end
    if (state == avg_pkg::S_DIVIDE && div_done) begin
      step_r <= div_quotient;
    end
    if (state == avg_pkg::S_EMIT && out_free) begin
      if (idx == '0) begin
        first_x <= cordic_x;
        first_y <= cordic_y;
      end
      idx     <= idx + 1'b1;
      angle_r <= angle_r + $signed({{(ACC_W - SPAN_W){1'b0}}, step_r});
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
    end else if (out_load) begin
      vertex_valid <= 1'b1;
    end else if (!vertex_stall) begin
      vertex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      vertex <= out_item;
    end
  end

  avg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (span_eff),
    .divisor  (seg_eff),
    .done     (div_done),
    .quotient (div_quotient)
  );

  avg_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .angle   (angle_r),
    .radius  (req_r.arc_radius),
    .stat    (cordic_stat),
    .point_x (cordic_x),
    .point_y (cordic_y)
  );

  // checks on sequencer and unit interplay
  `AVG_ASSERT_IMPLY(a_load_free, clk, rst, out_load, !vertex_valid || !vertex_stall, "vertex overwritten")
  `AVG_ASSERT_IMPLY(a_cordic_idle, clk, rst, cordic_start, !cordic_stat.busy, "cordic started while busy")
  `AVG_ASSERT_NEXT(a_last_idle, clk, rst, out_load && out_item.last, state == avg_pkg::S_IDLE, "no return to idle")
  `AVG_ASSERT_IMPLY(a_div_done, clk, rst, div_done, state == avg_pkg::S_DIVIDE, "stray divider result")

endmodule

`default_nettype wire
